[rtl/pfad_pkg.sv]
// Types and constants shared by the per-file activity rate detector.
package pfad_pkg;

    // Input word
    typedef struct packed {
        logic        func;
        logic [31:0] file_id;
        logic [2:0]  op_kind;
        logic [15:0] entropy_in;
        logic [31:0] now_seconds;
    } item_t;

    // Result word
    typedef struct packed {
        logic        suspicious;
        logic        dropped;
        logic [31:0] found_id;
        logic [3:0]  recent_count;
        logic [15:0] found_entropy;
        logic [1:0]  cause;
    } result_t;

    // Item functions
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_DETECT = 1'b1;

    // Operation kinds
    localparam logic [2:0] KIND_WRITE  = 3'd2;
    localparam logic [2:0] KIND_DELETE = 3'd3;
    localparam logic [2:0] KIND_RENAME = 3'd4;

    // Cause codes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_RATE   = 2'd1;
    localparam logic [1:0] CAUSE_RATE_H = 2'd2;
    localparam logic [1:0] CAUSE_WR_DEL = 2'd3;

    // Register map
    localparam logic [1:0] REG_RATE_THR = 2'd0;
    localparam logic [1:0] REG_ENT_LIM  = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;

    localparam logic [5:0]  RATE_DEFAULT  = 6'd50;
    localparam logic [15:0] ENT_LIM_RESET = 16'd3277;
    localparam logic [15:0] WINDOW_RESET  = 16'd60;

    // Result kinds
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_DROP = 2'd1,
        RES_HIT  = 2'd2
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      meta_rd;
        logic      step;
        logic      det_start;
        logic      ring_rd;
        logic      wr_rec;
        logic      wr_new;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic match;
        logic last_entry;
        logic empty;
        logic tbl_full;
        logic ring_last;
        logic hit;
    } stat_t;

endpackage

[rtl/pfad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/pfad_datapath.sv]
// Datapath: file table, history rings, scan counters and result registers.
module pfad_datapath #(
    parameter int ENTRIES = 64,
    parameter int HISTORY = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pfad_pkg::cmd_t   cmd,
    input  pfad_pkg::item_t  item,
    input  logic [5:0]       rate_threshold,
    input  logic [15:0]      entropy_limit,
    input  logic [15:0]      window_seconds,
    output pfad_pkg::stat_t  stat,
    output pfad_pkg::result_t result
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int NW = $clog2(HISTORY + 1);
    localparam int RD = ENTRIES * HISTORY;
    localparam int AW = (RD > 1) ? $clog2(RD) : 1;
    localparam int MW = 1 + SW + 16 + 32;

    pfad_pkg::item_t   in_reg;
    pfad_pkg::result_t res_reg, res_next;
    pfad_pkg::result_t out_reg;
    logic [IW-1:0] idx_reg;
    logic [AW-1:0] base_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] j_reg, jd_reg;
    logic          pend_reg;
    logic [NW-1:0] n_reg, n_next;
    logic          wr_reg, wr_next, del_reg, del_next;

    // Meta row: {full, slot, entropy, key}
    logic [MW-1:0] meta_rdata, meta_wdata;
    logic          m_full;
    logic [SW-1:0] m_slot;
    logic [15:0]   m_ent;
    logic [31:0]   m_key;
    logic [34:0]   ring_rdata;

    logic [SW-1:0] wslot, nslot;
    logic          nfull;
    logic [AW-1:0] ring_waddr, ring_raddr;

    assign {m_full, m_slot, m_ent, m_key} = meta_rdata;

    // Write of a record: new entry starts at slot zero
    assign wslot      = cmd.wr_new ? '0 : m_slot;
    assign nslot      = (wslot == SW'(HISTORY - 1)) ? '0 : wslot + 1'b1;
    assign nfull      = (cmd.wr_new ? 1'b0 : m_full) | (wslot == SW'(HISTORY - 1));
    assign meta_wdata = {nfull, nslot, in_reg.entropy_in, in_reg.file_id};
    assign ring_waddr = base_reg + AW'(wslot);
    assign ring_raddr = base_reg + AW'(j_reg);

    pfad_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
        .clk   (clk),
        .we    (cmd.wr_rec),
        .waddr (idx_reg),
        .wdata (meta_wdata),
        .re    (cmd.meta_rd),
        .raddr (idx_reg),
        .rdata (meta_rdata)
    );

    pfad_ram #(.WIDTH(35), .DEPTH(RD)) u_ring (
        .clk   (clk),
        .we    (cmd.wr_rec),
        .waddr (ring_waddr),
        .wdata ({in_reg.now_seconds, in_reg.op_kind}),
        .re    (cmd.ring_rd),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // History accumulation; slots never written read as empty
    logic [31:0] ts;
    logic [2:0]  kd;
    logic [32:0] age;
    logic        slot_ok, recent;
    assign ts      = ring_rdata[34:3];
    assign kd      = ring_rdata[2:0];
    assign slot_ok = m_full || (jd_reg < m_slot);
    assign age     = {1'b0, in_reg.now_seconds} - {1'b0, ts};
    assign recent  = slot_ok && (ts != 32'd0)
                     && (age[32] || (age[31:0] < {16'd0, window_seconds}));

    always_comb
    begin
        n_next   = n_reg;
        wr_next  = wr_reg;
        del_next = del_reg;
        if (cmd.det_start)
        begin
            n_next   = '0;
            wr_next  = 1'b0;
            del_next = 1'b0;
        end
        else if (pend_reg)
        begin
            if (recent)
            begin
                n_next = n_reg + 1'b1;
            end
            if (slot_ok && kd == pfad_pkg::KIND_WRITE)
            begin
                wr_next = 1'b1;
            end
            if (slot_ok && (kd == pfad_pkg::KIND_DELETE || kd == pfad_pkg::KIND_RENAME))
            begin
                del_next = 1'b1;
            end
        end
    end

    // Evaluation of one entry
    logic [5:0] thr;
    logic       rate_hit, hot;
    assign thr      = (rate_threshold == 6'd0) ? pfad_pkg::RATE_DEFAULT : rate_threshold;
    assign rate_hit = 32'(n_reg) >= 32'(thr);
    assign hot      = m_ent > entropy_limit;

    always_comb
    begin
        res_next = '0;
        case (cmd.res_kind)
            pfad_pkg::RES_DROP:
            begin
                res_next.dropped = 1'b1;
            end
            pfad_pkg::RES_HIT:
            begin
                res_next.suspicious    = 1'b1;
                res_next.found_id      = m_key;
                res_next.recent_count  = (32'(n_reg) > 32'd15) ? 4'd15 : 4'(n_reg);
                res_next.found_entropy = m_ent;
                res_next.cause         = rate_hit ? (hot ? pfad_pkg::CAUSE_RATE_H
                                                         : pfad_pkg::CAUSE_RATE)
                                                  : pfad_pkg::CAUSE_WR_DEL;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign stat.match      = (m_key == in_reg.file_id);
    assign stat.last_entry = (CW'(idx_reg) + 1'b1) == cnt_reg;
    assign stat.empty      = (cnt_reg == '0);
    assign stat.tbl_full   = (cnt_reg >= CW'(ENTRIES));
    assign stat.ring_last  = (j_reg == SW'(HISTORY - 1));
    assign stat.hit        = rate_hit || (wr_reg && del_reg && hot);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idx_reg  <= '0;
            base_reg <= '0;
            j_reg    <= '0;
            jd_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.ring_rd;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                base_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg  <= idx_reg + 1'b1;
                base_reg <= base_reg + AW'(HISTORY);
            end
            if (cmd.wr_rec && cmd.wr_new)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.det_start)
            begin
                j_reg <= '0;
            end
            else if (cmd.ring_rd)
            begin
                j_reg  <= j_reg + 1'b1;
                jd_reg <= j_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        wr_reg  <= wr_next;
        del_reg <= del_next;
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign result = out_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count above capacity");
`endif
endmodule

[rtl/pfad_ctrl.sv]
// Controller: sequences lookup, record writes and the detection scan.
module pfad_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_func,
    input  logic            result_ready,
    input  pfad_pkg::stat_t stat,
    output logic            item_ready,
    output logic            result_valid,
    output pfad_pkg::cmd_t  cmd
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LK_RD  = 10'b0000000010,
        S_LK_CMP = 10'b0000000100,
        S_WR_HIT = 10'b0000001000,
        S_WR_NEW = 10'b0000010000,
        S_D_META = 10'b0000100000,
        S_D_RING = 10'b0001000000,
        S_D_LAST = 10'b0010000000,
        S_D_EVAL = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = pfad_pkg::RES_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_func == pfad_pkg::FUNC_RECORD)
                    begin
                        state_next = stat.empty ? S_WR_NEW : S_LK_RD;
                    end
                    else if (stat.empty)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        state_next = S_D_META;
                    end
                end
            end
            S_LK_RD:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_WR_HIT;
                end
                else if (!stat.last_entry)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_LK_RD;
                end
                else if (stat.tbl_full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = pfad_pkg::RES_DROP;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_WR_NEW;
                end
            end
            S_WR_HIT:
            begin
                cmd.wr_rec   = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_FIN;
            end
            S_WR_NEW:
            begin
                cmd.wr_rec   = 1'b1;
                cmd.wr_new   = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_FIN;
            end
            S_D_META:
            begin
                cmd.meta_rd   = 1'b1;
                cmd.det_start = 1'b1;
                state_next    = S_D_RING;
            end
            S_D_RING:
            begin
                cmd.ring_rd = 1'b1;
                if (stat.ring_last)
                begin
                    state_next = S_D_LAST;
                end
            end
            S_D_LAST:
            begin
                state_next = S_D_EVAL;
            end
            S_D_EVAL:
            begin
                if (stat.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = pfad_pkg::RES_HIT;
                    state_next   = S_FIN;
                end
                else if (stat.last_entry)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_D_META;
                end
            end
            S_FIN:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = valid_reg;

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!valid_reg || result_ready))
        else $error("result overwritten before taken");
`endif
endmodule

[rtl/per_file_activity_rate_detector.sv]
// Top level: register port, controller and datapath of the file activity detector.
//
//  channel  | handshake                     | payload
//  item     | item_valid / item_ready       | item   (pfad_pkg::item_t)
//  result   | result_valid / result_ready   | result (pfad_pkg::result_t)
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A record scans the table one entry at a time, a table read then a compare, and
// updates the entry it finds, appends a new one or drops the word on a full table;
// a detect reads per entry one table row and HISTORY ring slots, one read port per RAM.
// Reset clears the table by its entry count; ring slots never written read as
// empty by a per-entry fill mark, so no clearing pass is needed.
// A new word is taken while a finished result waits in the output register.
module per_file_activity_rate_detector #(
    parameter int ENTRIES = 64,
    parameter int HISTORY = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pfad_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output pfad_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [5:0]  rate_thr_reg;
    logic [15:0] ent_lim_reg;
    logic [15:0] window_reg;
    logic        cfg_we;

    pfad_pkg::cmd_t  cmd;
    pfad_pkg::stat_t stat;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_thr_reg <= pfad_pkg::RATE_DEFAULT;
            ent_lim_reg  <= pfad_pkg::ENT_LIM_RESET;
            window_reg   <= pfad_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                pfad_pkg::REG_RATE_THR: rate_thr_reg <= pwdata[5:0];
                pfad_pkg::REG_ENT_LIM:  ent_lim_reg  <= pwdata[15:0];
                pfad_pkg::REG_WINDOW:   window_reg   <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pfad_pkg::REG_RATE_THR: prdata = {26'd0, rate_thr_reg};
            pfad_pkg::REG_ENT_LIM:  prdata = {16'd0, ent_lim_reg};
            pfad_pkg::REG_WINDOW:   prdata = {16'd0, window_reg};
            default:                prdata = 32'd0;
        endcase
    end

    pfad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_func    (item.func),
        .result_ready (result_ready),
        .stat         (stat),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    pfad_datapath #(.ENTRIES(ENTRIES), .HISTORY(HISTORY)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item           (item),
        .rate_threshold (rate_thr_reg),
        .entropy_limit  (ent_lim_reg),
        .window_seconds (window_reg),
        .stat           (stat),
        .result         (result)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("second word accepted while busy");
    a_cause_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.suspicious == (result.cause != pfad_pkg::CAUSE_NONE)))
        else $error("cause disagrees with suspicious flag");
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.suspicious && result.dropped))
        else $error("dropped record reported as suspicious");
`endif
endmodule

[tb/sv/per_file_activity_rate_detector_tb.sv]
// Testbench for the per-file activity rate detector: directed and random words, scoreboard.
`timescale 1ns / 100ps

module per_file_activity_rate_detector_tb;

    localparam int ENTRIES = 64;
    localparam int HISTORY = 10;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    pfad_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    pfad_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    per_file_activity_rate_detector #(
        .ENTRIES(ENTRIES),
        .HISTORY(HISTORY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Shadow of the file table and registers
    logic [5:0]  thr_shadow;
    logic [15:0] elim_shadow;
    logic [15:0] win_shadow;
    int          files_used;
    logic [31:0] file_key   [ENTRIES];
    logic [31:0] file_stamp [ENTRIES][HISTORY];
    logic [2:0]  file_kind  [ENTRIES][HISTORY];
    int          file_slot  [ENTRIES];
    logic [15:0] file_ent   [ENTRIES];

    pfad_pkg::result_t pending_verdicts[$];
    int          errors;
    int          n_records;
    int          n_detects;
    int          n_drops;
    int          n_cause[4];
    int          stall_left;
    logic [31:0] key_pool[100];
    logic [31:0] clock_now;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Number of ring stamps of one file that fall inside the window
    function automatic int count_in_window(int e, logic [31:0] now);
        int     n;
        longint age;
        n = 0;
        for (int j = 0; j < HISTORY; j++)
        begin
            age = longint'(now) - longint'(file_stamp[e][j]);
            if (file_stamp[e][j] != 32'd0 && age < longint'(win_shadow))
                n++;
        end
        return n;
    endfunction

    // Apply one word to the shadow table and return the verdict it must produce
    function automatic pfad_pkg::result_t predict_verdict(pfad_pkg::item_t w);
        pfad_pkg::result_t r;
        int      e;
        int      n;
        int      thr;
        logic    hot;
        logic    wr;
        logic    del;
        r = '0;
        if (w.func == pfad_pkg::FUNC_RECORD)
        begin
            n_records++;
            e = files_used;
            for (int i = 0; i < files_used; i++)
                if (file_key[i] == w.file_id && e == files_used)
                    e = i;
            if (e == files_used)
            begin
                if (files_used >= ENTRIES)
                begin
                    r.dropped = 1'b1;
                    n_drops++;
                    return r;
                end
                files_used++;
                file_key[e] = w.file_id;
                file_slot[e] = 0;
            end
            file_stamp[e][file_slot[e]] = w.now_seconds;
            file_kind[e][file_slot[e]] = w.op_kind;
            file_ent[e] = w.entropy_in;
            file_slot[e] = (file_slot[e] + 1) % HISTORY;
            return r;
        end
        n_detects++;
        thr = (thr_shadow == 6'd0) ? int'(pfad_pkg::RATE_DEFAULT) : int'(thr_shadow);
        for (int i = 0; i < files_used; i++)
        begin
            n = count_in_window(i, w.now_seconds);
            hot = file_ent[i] > elim_shadow;
            wr = 1'b0;
            del = 1'b0;
            for (int j = 0; j < HISTORY; j++)
            begin
                if (file_kind[i][j] == pfad_pkg::KIND_WRITE)
                    wr = 1'b1;
                else if (file_kind[i][j] == pfad_pkg::KIND_DELETE
                         || file_kind[i][j] == pfad_pkg::KIND_RENAME)
                    del = 1'b1;
            end
            if (n >= thr || (wr && del && hot))
            begin
                r.suspicious = 1'b1;
                r.found_id = file_key[i];
                r.recent_count = (n > 15) ? 4'd15 : 4'(n);
                r.found_entropy = file_ent[i];
                if (n >= thr)
                    r.cause = hot ? pfad_pkg::CAUSE_RATE_H : pfad_pkg::CAUSE_RATE;
                else
                    r.cause = pfad_pkg::CAUSE_WR_DEL;
                n_cause[r.cause]++;
                return r;
            end
        end
        return r;
    endfunction

    // Result receiver: random backpressure, short mostly, occasionally long
    initial
    begin
        result_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready = 1'b1;
                case ($urandom_range(0, 99)) inside
                    [0:14]:  stall_left = $urandom_range(1, 3);
                    [15:16]: stall_left = $urandom_range(20, 60);
                    default: stall_left = 0;
                endcase
            end
        end
    end

    // Scoreboard: each accepted verdict against the oldest prediction
    always @(posedge clk)
    begin
        pfad_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.suspicious !== want.suspicious)
                    $display("%0t: suspicious exp %h got %h", $time, want.suspicious,
                             result.suspicious);
                if (result.dropped !== want.dropped)
                    $display("%0t: dropped exp %h got %h", $time, want.dropped,
                             result.dropped);
                if (result.found_id !== want.found_id)
                    $display("%0t: found_id exp %h got %h", $time, want.found_id,
                             result.found_id);
                if (result.recent_count !== want.recent_count)
                    $display("%0t: recent_count exp %0d got %0d", $time, want.recent_count,
                             result.recent_count);
                if (result.found_entropy !== want.found_entropy)
                    $display("%0t: found_entropy exp %h got %h", $time,
                             want.found_entropy, result.found_entropy);
                if (result.cause !== want.cause)
                    $display("%0t: cause exp %0d got %0d", $time, want.cause, result.cause);
                if (result !== want)
                    errors++;
            end
        end
    end

    // Send one word; valid stays high after acceptance unless a gap follows
    task automatic send_word(logic func, logic [31:0] id, logic [2:0] kind,
                             logic [15:0] ent, logic [31:0] now);
        pfad_pkg::item_t w;
        int    gap;
        w.func = func;
        w.file_id = id;
        w.op_kind = kind;
        w.entropy_in = ent;
        w.now_seconds = now;
        @(negedge clk);
        item = w;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        pending_verdicts.push_back(predict_verdict(w));
        case ($urandom_range(0, 99)) inside
            [0:39]:  gap = 0;
            [40:95]: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(20, 80);
        endcase
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic record(logic [31:0] id, logic [2:0] kind, logic [15:0] ent,
                          logic [31:0] now);
        send_word(pfad_pkg::FUNC_RECORD, id, kind, ent, now);
    endtask

    task automatic detect(logic [31:0] now);
        send_word(pfad_pkg::FUNC_DETECT, $urandom, 3'($urandom), 16'($urandom), now);
    endtask

    // Stop sending and wait until every verdict has come back
    task automatic drain();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Register write: setup then access phase
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            pfad_pkg::REG_RATE_THR: thr_shadow = value[5:0];
            pfad_pkg::REG_ENT_LIM:  elim_shadow = value[15:0];
            default:                win_shadow = value[15:0];
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(logic [5:0] thr, logic [15:0] elim, logic [15:0] win);
        drain();
        reg_write(pfad_pkg::REG_RATE_THR, 32'(thr));
        reg_write(pfad_pkg::REG_ENT_LIM, 32'(elim));
        reg_write(pfad_pkg::REG_WINDOW, 32'(win));
    endtask

    // Extremes, every op code, write-then-delete, rate hits, future stamps, odd registers
    task automatic test_directed();
        detect(32'd1);
        record(32'h0000_0000, 3'd0, 16'h0000, 32'd1);
        record(32'hFFFF_FFFF, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        detect(32'hFFFF_FFFF);
        record(32'hA5A5_0001, pfad_pkg::KIND_WRITE, 16'hFFFF, 32'd100);
        record(32'hA5A5_0001, pfad_pkg::KIND_DELETE, 16'hFFFF, 32'd101);
        record(32'h5A5A_0002, 3'd1, 16'h2000, 32'd102);
        record(32'h5A5A_0002, pfad_pkg::KIND_WRITE, 16'h2000, 32'd103);
        record(32'h5A5A_0002, pfad_pkg::KIND_RENAME, 16'hF000, 32'd104);
        record(32'h5A5A_0002, 3'd5, 16'hF000, 32'd105);
        record(32'h5A5A_0002, 3'd6, 16'hF000, 32'd106);
        detect(32'd110);
        configure(6'd2, 16'h0CCD, 16'd60);
        detect(32'd110);
        detect(32'd50);
        configure(6'd0, 16'hFFFF, 16'd0);
        detect(32'd110);
        configure(6'd1, 16'd0, 16'hFFFF);
        detect(32'd2);
        detect(32'hFFFF_FFFF);
    endtask

    // Half the time a burst on one file followed by a detect; the rest single words
    task automatic test_random(int count, int pool_n, logic [31:0] base);
        int          sent;
        int          m;
        logic [31:0] key;
        logic [15:0] ent;
        sent = 0;
        clock_now = base;
        while (sent < count)
        begin
            key = key_pool[$urandom_range(0, pool_n - 1)];
            case ($urandom_range(0, 4))
                0:       ent = 16'($urandom);
                1:       ent = elim_shadow;
                2:       ent = elim_shadow + 16'd1;
                3:       ent = 16'hFFFF;
                default: ent = 16'($urandom_range(0, 16));
            endcase
            if ($urandom_range(0, 99) < 5)
                clock_now += $urandom_range(0, 300);
            else
                clock_now += $urandom_range(0, 3);
            if (clock_now == 32'd0)
                clock_now = 32'd1;
            case ($urandom_range(0, 19)) inside
                [0:9]:
                begin
                    m = $urandom_range(2, 12);
                    repeat (m)
                    begin
                        record(key, 3'($urandom_range(1, 4)), ent, clock_now);
                        clock_now += $urandom_range(0, 2);
                    end
                    detect(clock_now);
                    sent += m + 1;
                end
                [10:16]:
                begin
                    record(key, 3'($urandom_range(0, 7)), ent, clock_now);
                    sent++;
                end
                [17:18]:
                begin
                    detect(clock_now);
                    sent++;
                end
                default:
                begin
                    detect($urandom_range(1, 32'hFFFF_FFFF));
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        n_records = 0;
        n_detects = 0;
        n_drops = 0;
        n_cause = '{default: 0};
        thr_shadow = pfad_pkg::RATE_DEFAULT;
        elim_shadow = pfad_pkg::ENT_LIM_RESET;
        win_shadow = pfad_pkg::WINDOW_RESET;
        files_used = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            file_slot[i] = 0;
            for (int j = 0; j < HISTORY; j++)
            begin
                file_stamp[i][j] = '0;
                file_kind[i][j] = '0;
            end
        end
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        configure(6'd3, 16'd3277, 16'd60);
        test_random(256, 10, 32'd1000);
        configure(6'd1, 16'd0, 16'd1);
        test_random(256, 20, $urandom);
        configure(6'd10, 16'h8000, 16'hFFFF);
        test_random(256, 35, 32'hFFFF_E000);
        configure(6'd63, 16'hFFFF, 16'd20);
        test_random(256, 60, 32'd1);
        configure(6'd6, 16'd100, 16'd5);
        test_random(256, 100, $urandom);
        drain();
        repeat (20) @(posedge clk);

        $display("Ran %0d records (%0d dropped on a full table) and %0d detects,",
                 n_records, n_drops, n_detects);
        $display("flagged by rate %0d, rate with entropy %0d, write then delete %0d.",
                 n_cause[1], n_cause[2], n_cause[3]);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
